[src/rga_pkg.sv]
// rga_pkg: shared types and constants of the run group aggregator
// used by every module under src; depends on nothing else
`timescale 1ns / 1ps

package rga_pkg;

    localparam int KEY_W          = 64;
    localparam int IN_VALUE_W     = 32;
    localparam int SUM_W          = 64;
    localparam int CNT_OUT_W      = 32;
    localparam int NUM_LANES      = 4;
    localparam int NUM_SQUARES    = 3;
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 32;

    localparam int IN_DATA_W  = KEY_W + NUM_LANES * IN_VALUE_W;
    localparam int OUT_DATA_W = KEY_W + CNT_OUT_W + (NUM_LANES + NUM_SQUARES) * SUM_W;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_LVL_W = 3;

    typedef struct packed {
        logic advance;
        logic fresh;
    } lane_ctrl_t;

    typedef struct packed {
        logic w0_en;
        logic w1_en;
        logic w0_old;
    } wr_ctrl_t;

    typedef struct packed {
        logic                                fin;
        logic [NUM_SQUARES-1:0][SUM_W-1:0]   squares;
        logic [NUM_LANES-1:0][SUM_W-1:0]     sums;
        logic [CNT_OUT_W-1:0]                count;
        logic [KEY_W-1:0]                    key;
    } result_t;

endpackage

[src/rga_lane.sv]
// rga_lane: one value lane, running sum, optional registered square and sum of squares
// depends on rga_pkg
`timescale 1ns / 1ps

module rga_lane
    import rga_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter bit SQUARE     = 1'b1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_load,
    input  logic [IN_VALUE_W-1:0] in_value,
    input  lane_ctrl_t            ctrl,
    output logic [SUM_W-1:0]      sum_cur,
    output logic [SUM_W-1:0]      sum_next,
    output logic [SUM_W-1:0]      sq_cur,
    output logic [SUM_W-1:0]      sq_next
);

    logic [VALUE_BITS-1:0] val_reg;
    logic [SUM_W-1:0]      sum_reg;

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            val_reg <= in_value[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_next = ctrl.fresh ? SUM_W'(val_reg) : sum_reg + SUM_W'(val_reg);
    assign sum_cur  = sum_reg;

    generate
        if (SQUARE)
        begin : g_square
            logic [2*VALUE_BITS-1:0] sq_term_reg;
            logic [SUM_W-1:0]        sq_reg;

            // square taken at the input, registered before the accumulate
            always_ff @(posedge clk)
            begin
                if (in_load)
                begin
                    sq_term_reg <= in_value[VALUE_BITS-1:0] * in_value[VALUE_BITS-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_reg <= '0;
                end
                else if (ctrl.advance)
                begin
                    sq_reg <= sq_next;
                end
            end

            assign sq_next = ctrl.fresh ? SUM_W'(sq_term_reg) : sq_reg + SUM_W'(sq_term_reg);
            assign sq_cur  = sq_reg;
        end
        else
        begin : g_no_square
            assign sq_next = '0;
            assign sq_cur  = '0;
        end
    endgenerate

endmodule

[src/rga_ctl.sv]
// rga_ctl: tuple stage, key compare, run state and count, result write control
// depends on rga_pkg
`timescale 1ns / 1ps

module rga_ctl
    import rga_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int CNT_W      = (COUNT_BITS > CNT_OUT_W) ? CNT_OUT_W : COUNT_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [KEY_W-1:0] in_key,
    input  logic             in_last,
    input  logic             q_room,
    output lane_ctrl_t       lane_ctrl,
    output wr_ctrl_t         wr_ctrl,
    output logic [KEY_W-1:0] open_key,
    output logic [KEY_W-1:0] new_key,
    output logic [CNT_W-1:0] count_cur,
    output logic [CNT_W-1:0] count_next
);

    logic             s1_valid_reg, s1_valid_next;
    logic [KEY_W-1:0] s1_key_reg;
    logic             s1_last_reg;
    logic             run_open_reg, run_open_next;
    logic [KEY_W-1:0] open_key_reg, open_key_next;
    logic [CNT_W-1:0] count_reg;
    logic             adv;
    logic             accept;
    logic             match;
    logic             emit_old;
    logic             emit_fin;

    assign adv      = s1_valid_reg && q_room;
    assign in_ready = !s1_valid_reg || q_room;
    assign accept   = in_valid && in_ready;
    assign match    = run_open_reg && (open_key_reg == s1_key_reg);
    assign emit_old = adv && run_open_reg && !match;
    assign emit_fin = adv && s1_last_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        run_open_next = adv ? !s1_last_reg : run_open_reg;
        open_key_next = adv ? s1_key_reg : open_key_reg;
        // saturating count, restart at one on a new run
        if (!match)
        begin
            count_next = CNT_W'(1);
        end
        else if (&count_reg)
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            run_open_reg <= 1'b0;
            open_key_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            run_open_reg <= run_open_next;
            open_key_reg <= open_key_next;
            if (adv)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg  <= in_key;
            s1_last_reg <= in_last;
        end
    end

    assign lane_ctrl.advance = adv;
    assign lane_ctrl.fresh   = !match;

    assign wr_ctrl.w0_en  = emit_old || emit_fin;
    assign wr_ctrl.w1_en  = emit_old && emit_fin;
    assign wr_ctrl.w0_old = emit_old;

    assign open_key  = open_key_reg;
    assign new_key   = s1_key_reg;
    assign count_cur = count_reg;

endmodule

[src/rga_outq.sv]
// rga_outq: merging stage, a four-entry result queue taking up to two results a cycle
// depends on rga_pkg
`timescale 1ns / 1ps

module rga_outq
    import rga_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  wr_ctrl_t wr_ctrl,
    input  result_t  old_res,
    input  result_t  new_res,
    output logic     room,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_res
);

    result_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_LVL_W-1:0]   level_reg, level_next;
    logic [Q_PTR_W-1:0]   wr_ptr_p1;
    logic                 pop;
    result_t              w0_data;

    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign w0_data   = wr_ctrl.w0_old ? old_res : new_res;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(wr_ctrl.w0_en) + Q_PTR_W'(wr_ctrl.w1_en);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        level_next  = level_reg + Q_LVL_W'(wr_ctrl.w0_en) + Q_LVL_W'(wr_ctrl.w1_en)
                      - Q_LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ctrl.w0_en)
        begin
            mem_reg[wr_ptr_reg] <= w0_data;
        end
        // second result is always the final flush of the new run
        if (wr_ctrl.w1_en)
        begin
            mem_reg[wr_ptr_p1] <= new_res;
        end
    end

    assign room      = level_reg <= Q_LVL_W'(Q_DEPTH - 2);
    assign out_valid = level_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];

endmodule

[src/run_group_aggregator.sv]
// run_group_aggregator: top level, four value lanes, run control and result queue
// depends on rga_pkg, rga_lane, rga_ctl and rga_outq
`timescale 1ns / 1ps

// Merges runs of consecutive tuples with equal keys into one result each: count
// (saturating), four sums and three sums of squares, all modulo 2^64. A result
// leaves when the key changes, and a tuple with tlast flushes its run as a result
// with tlast set. One tuple is accepted per clock, sustained, while results drain;
// a tuple that both closes a run and flushes gives two results, and the output port
// moves one result per clock, which then sets the pace. Between tuple accept and the
// results it causes being offered, the tuple and its three squares are registered in
// the tuple stage, and key compare and accumulate then write the four-entry result
// queue once it has room. The input stalls only while the queue holds three or more
// results.

module run_group_aggregator
    import rga_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // group_key, value_a, value_b, value_c, value_d
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // run_key, run_count, sum_a, sum_b, sum_c, sum_d, squares_a, squares_b, squares_c
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int CNT_W = (COUNT_BITS > CNT_OUT_W) ? CNT_OUT_W : COUNT_BITS;

    lane_ctrl_t                      lane_ctrl;
    wr_ctrl_t                        wr_ctrl;
    logic                            in_load;
    logic                            q_room;
    logic [KEY_W-1:0]                open_key;
    logic [KEY_W-1:0]                new_key;
    logic [CNT_W-1:0]                count_cur;
    logic [CNT_W-1:0]                count_next;
    logic [NUM_LANES-1:0][SUM_W-1:0] lane_sum_cur;
    logic [NUM_LANES-1:0][SUM_W-1:0] lane_sum_next;
    logic [NUM_LANES-1:0][SUM_W-1:0] lane_sq_cur;
    logic [NUM_LANES-1:0][SUM_W-1:0] lane_sq_next;
    result_t                         old_res;
    result_t                         new_res;
    result_t                         out_res;

    assign in_load = s_axis_tvalid && s_axis_tready;

    rga_ctl #(
        .COUNT_BITS (COUNT_BITS),
        .CNT_W      (CNT_W)
    ) u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_key     (s_axis_tdata[KEY_W-1:0]),
        .in_last    (s_axis_tlast),
        .q_room     (q_room),
        .lane_ctrl  (lane_ctrl),
        .wr_ctrl    (wr_ctrl),
        .open_key   (open_key),
        .new_key    (new_key),
        .count_cur  (count_cur),
        .count_next (count_next)
    );

    generate
        for (genvar i = 0; i < NUM_LANES; i++)
        begin : g_lane
            rga_lane #(
                .VALUE_BITS (VALUE_BITS),
                .SQUARE     (i < NUM_SQUARES)
            ) u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_load  (in_load),
                .in_value (s_axis_tdata[KEY_W + i*IN_VALUE_W +: IN_VALUE_W]),
                .ctrl     (lane_ctrl),
                .sum_cur  (lane_sum_cur[i]),
                .sum_next (lane_sum_next[i]),
                .sq_cur   (lane_sq_cur[i]),
                .sq_next  (lane_sq_next[i])
            );
        end
    endgenerate

    // closing run before this tuple, and the run that now holds it
    assign old_res.key     = open_key;
    assign old_res.count   = CNT_OUT_W'(count_cur);
    assign old_res.sums    = lane_sum_cur;
    assign old_res.squares = lane_sq_cur[NUM_SQUARES-1:0];
    assign old_res.fin     = 1'b0;

    assign new_res.key     = new_key;
    assign new_res.count   = CNT_OUT_W'(count_next);
    assign new_res.sums    = lane_sum_next;
    assign new_res.squares = lane_sq_next[NUM_SQUARES-1:0];
    assign new_res.fin     = 1'b1;

    rga_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_ctrl   (wr_ctrl),
        .old_res   (old_res),
        .new_res   (new_res),
        .room      (q_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.squares, out_res.sums, out_res.count, out_res.key};
    assign m_axis_tlast = out_res.fin;

`ifndef ASSERT_OFF
    // input only stalls behind a backed-up result queue
    a_stall_has_results: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // every delivered run holds at least one tuple
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[KEY_W +: CNT_OUT_W] != '0))
        else $error("result with zero count");

    // two results from one tuple: the first closes a run, the second is the flush
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ctrl.w1_en |-> wr_ctrl.w0_old)
        else $error("double write without a closing run");
`endif

endmodule
